// ----- hw/rtl/jnv_pkg.sv -----
// jnv_pkg: shared types, constants and helper functions of the JSON number validator
// no dependencies; used by the channel interfaces and imported by every RTL module

package jnv_pkg;

    // widths fixed by the field formats
    localparam int LENGTH_BITS_DEFAULT = 16;
    localparam int TOKEN_LEN_W         = 16;
    localparam int FRAC_W              = 16;
    localparam int CNT_W               = 10;
    localparam int EXP_W               = 10;
    localparam int EXP_SUM_W           = 14;
    localparam int STATUS_W            = 3;
    localparam int ADDR_W              = 3;
    localparam int DATA_W              = 32;

    // register reset values
    localparam logic [CNT_W-1:0] MAX_INT_RESET = 10'd308;
    localparam logic [EXP_W-1:0] MAX_EXP_RESET = 10'd324;

    // character codes
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_POINT    = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_E_LO     = 8'h65;
    localparam logic [7:0] CH_E_UP     = 8'h45;

    // lexer phases
    typedef enum logic [7:0] {
        PH_WS      = 8'b0000_0001,
        PH_SIGN    = 8'b0000_0010,
        PH_ZERO    = 8'b0000_0100,
        PH_INT     = 8'b0000_1000,
        PH_FRAC    = 8'b0001_0000,
        PH_EXPMARK = 8'b0010_0000,
        PH_EXP     = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } phase_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_DIGIT  = 3'd1,
        ST_BAD_ZERO  = 3'd2,
        ST_INT_OVF   = 3'd3,
        ST_NO_FRAC   = 3'd4,
        ST_EXP_OVF   = 3'd5,
        ST_NO_EXP    = 3'd6,
        ST_BAD_TAIL  = 3'd7
    } status_t;

    // configuration register indexes
    typedef enum logic {
        REG_MAX_INT = 1'b0,
        REG_MAX_EXP = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0] max_int_digits;
        logic [EXP_W-1:0] max_exp_value;
    } cfg_t;

    typedef struct packed {
        status_t                status;
        logic [TOKEN_LEN_W-1:0] token_length;
        logic                   is_negative;
        logic                   integer_form;
        logic [CNT_W-1:0]       integer_digits;
        logic [FRAC_W-1:0]      fraction_digits;
        logic [EXP_W-1:0]       exponent_value;
        logic                   exponent_negative;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_term(input logic [7:0] c);
        return is_space(c) || (c == CH_COMMA) || (c == CH_RBRACKET) || (c == CH_RBRACE);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ----- hw/rtl/jnv_if.sv -----
// jnv_if: valid/ready channel interfaces for text bytes and number results
// depends on jnv_pkg for field widths

interface jnv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       buffer_end;

    modport source (output valid, output text_byte, output buffer_end, input ready);
    modport sink   (input valid, input text_byte, input buffer_end, output ready);
endinterface

interface jnv_out_if;
    logic                            valid;
    logic                            ready;
    logic [jnv_pkg::STATUS_W-1:0]    status;
    logic [jnv_pkg::TOKEN_LEN_W-1:0] token_length;
    logic                            is_negative;
    logic                            integer_form;
    logic [jnv_pkg::CNT_W-1:0]       integer_digits;
    logic [jnv_pkg::FRAC_W-1:0]      fraction_digits;
    logic [jnv_pkg::EXP_W-1:0]       exponent_value;
    logic                            exponent_negative;

    modport source (output valid, output status, output token_length, output is_negative,
                    output integer_form, output integer_digits, output fraction_digits,
                    output exponent_value, output exponent_negative, input ready);
    modport sink   (input valid, input status, input token_length, input is_negative,
                    input integer_form, input integer_digits, input fraction_digits,
                    input exponent_value, input exponent_negative, output ready);
endinterface

// ----- hw/rtl/json_number_validator_top.sv -----
// json_number_validator_top: input register, lexer step and result register
// depends on jnv_pkg, jnv_if, jnv_cfg_regs and jnv_lexer
//
// Usage:
//   byte_chan carries one text byte per request with buffer_end on the
//   buffer's last byte. result_chan carries one result per number token:
//   status, length, sign, digit counts and exponent. A token closes at a
//   terminator byte, at the buffer's last byte or at the first error; later
//   bytes of that buffer are consumed without a result. Limits are written
//   through the APB port (0x0 integer digits, 0x4 exponent value); the user
//   must do so only while no buffer is in flight; the block never checks.
// Timing:
//   a request is registered in the input register on acceptance and
//   evaluated from there once the result register is free; the result of
//   the byte closing the token is registered in the result register.
//   One byte per cycle is sustained while result_chan is ready; the rate
//   is set by the combinational lexer step between the two registers.
//   When result_chan stalls with a result pending, the lexer holds and
//   byte_chan takes at most one more byte into the input register.
// Reset:
//   rst_n clears both registers' valid flags and the token state and sets
//   the limits to 308 integer digits and exponent 324.

module json_number_validator_top
#(
    parameter int LENGTH_BITS = jnv_pkg::LENGTH_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    jnv_in_if.sink                      byte_chan,
    jnv_out_if.source                   result_chan,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jnv_pkg::ADDR_W-1:0]  paddr,
    input  logic [jnv_pkg::DATA_W-1:0]  pwdata,
    output logic [jnv_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import jnv_pkg::*;

    cfg_t       cfg;
    logic       in_vld_reg;
    logic [7:0] in_txt_reg;
    logic       in_last_reg;
    logic       out_vld_reg;
    result_t    out_res_reg;
    logic       out_free;
    logic       step;
    logic       got;
    result_t    res;

    // configuration registers
    jnv_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake between the two registers
    assign out_free        = !out_vld_reg || result_chan.ready;
    assign step            = in_vld_reg && out_free;
    assign byte_chan.ready = !in_vld_reg || step;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (byte_chan.ready)
        begin
            in_vld_reg <= byte_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_chan.ready && byte_chan.valid)
        begin
            in_txt_reg  <= byte_chan.text_byte;
            in_last_reg <= byte_chan.buffer_end;
        end
    end

    // lexer step
    jnv_lexer #(.LENGTH_BITS(LENGTH_BITS)) u_lexer
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .txt   (in_txt_reg),
        .last  (in_last_reg),
        .cfg   (cfg),
        .got   (got),
        .res   (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (got)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result_chan.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (got)
        begin
            out_res_reg <= res;
        end
    end

    assign result_chan.valid             = out_vld_reg;
    assign result_chan.status            = out_res_reg.status;
    assign result_chan.token_length      = out_res_reg.token_length;
    assign result_chan.is_negative       = out_res_reg.is_negative;
    assign result_chan.integer_form      = out_res_reg.integer_form;
    assign result_chan.integer_digits    = out_res_reg.integer_digits;
    assign result_chan.fraction_digits   = out_res_reg.fraction_digits;
    assign result_chan.exponent_value    = out_res_reg.exponent_value;
    assign result_chan.exponent_negative = out_res_reg.exponent_negative;

endmodule

// ----- hw/rtl/jnv_cfg_regs.sv -----
// jnv_cfg_regs: APB-style register file holding the digit and exponent limits
// depends on jnv_pkg

module jnv_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jnv_pkg::ADDR_W-1:0]  paddr,
    input  logic [jnv_pkg::DATA_W-1:0]  pwdata,
    output logic [jnv_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output jnv_pkg::cfg_t               cfg
);
    import jnv_pkg::*;

    logic [CNT_W-1:0] max_int_reg;
    logic [EXP_W-1:0] max_exp_reg;
    logic             wr_en;
    reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[2]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_int_reg <= MAX_INT_RESET;
            max_exp_reg <= MAX_EXP_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MAX_INT: max_int_reg <= pwdata[CNT_W-1:0];
                REG_MAX_EXP: max_exp_reg <= pwdata[EXP_W-1:0];
                default:     max_int_reg <= max_int_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_MAX_INT: prdata = DATA_W'(max_int_reg);
            REG_MAX_EXP: prdata = DATA_W'(max_exp_reg);
            default:     prdata = '0;
        endcase
    end

    assign cfg.max_int_digits = max_int_reg;
    assign cfg.max_exp_value  = max_exp_reg;

endmodule

// ----- hw/rtl/jnv_lexer.sv -----
// jnv_lexer: token state registers and the per-byte grammar step of the number check
// depends on jnv_pkg

module jnv_lexer
#(
    parameter int LENGTH_BITS = jnv_pkg::LENGTH_BITS_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      txt,
    input  logic            last,
    input  jnv_pkg::cfg_t   cfg,
    output logic            got,
    output jnv_pkg::result_t res
);
    import jnv_pkg::*;

    // token state
    phase_t                 phase_reg;
    logic [LENGTH_BITS-1:0] len_reg;
    logic [CNT_W-1:0]       int_cnt_reg;
    logic [FRAC_W-1:0]      frac_cnt_reg;
    logic [EXP_W-1:0]       exp_acc_reg;
    logic                   exp_seen_reg;
    logic                   exp_minus_reg;
    logic                   minus_reg;

    // state after this byte, before the token is closed
    phase_t                 phase_tok;
    logic [LENGTH_BITS-1:0] len_tok;
    logic [CNT_W-1:0]       int_tok;
    logic [FRAC_W-1:0]      frac_tok;
    logic [EXP_W-1:0]       exp_tok;
    logic                   exp_seen_tok;
    logic                   exp_minus_tok;
    logic                   minus_tok;

    logic [LENGTH_BITS-1:0] len_inc;
    logic [EXP_SUM_W-1:0]   exp_sum;
    logic                   zero_lead;
    logic                   active;
    logic                   hit;
    status_t                hit_status;
    status_t                end_status;
    logic                   do_int;
    logic                   do_exp;
    logic                   do_after;
    logic                   allow_point;
    status_t                bad_status;
    logic [TOKEN_LEN_W-1:0] len_out;

    assign active    = (phase_reg != PH_DONE);
    assign len_inc   = (&len_reg) ? len_reg : len_reg + 1'b1;
    assign zero_lead = (phase_reg != PH_INT) && (txt == CH_ZERO);
    assign exp_sum   = {exp_acc_reg, 3'b000} + {3'b000, exp_acc_reg, 1'b0}
                     + {10'd0, txt[3:0]};

    // one grammar step
    always_comb
    begin
        phase_tok     = phase_reg;
        len_tok       = len_reg;
        int_tok       = int_cnt_reg;
        frac_tok      = frac_cnt_reg;
        exp_tok       = exp_acc_reg;
        exp_seen_tok  = exp_seen_reg;
        exp_minus_tok = exp_minus_reg;
        minus_tok     = minus_reg;
        hit           = 1'b0;
        hit_status    = ST_OK;
        do_int        = 1'b0;
        do_exp        = 1'b0;
        do_after      = 1'b0;
        allow_point   = 1'b0;
        bad_status    = ST_BAD_TAIL;

        unique case (phase_reg)
            PH_WS:
            begin
                if (is_space(txt))
                begin
                    phase_tok = PH_WS;
                end
                else if (txt == CH_MINUS)
                begin
                    minus_tok = 1'b1;
                    len_tok   = len_inc;
                    phase_tok = PH_SIGN;
                end
                else if (is_digit(txt))
                begin
                    do_int = 1'b1;
                end
                else
                begin
                    hit        = 1'b1;
                    hit_status = ST_NO_DIGIT;
                end
            end
            PH_SIGN:
            begin
                if (is_digit(txt))
                begin
                    do_int = 1'b1;
                end
                else
                begin
                    hit        = 1'b1;
                    hit_status = ST_NO_DIGIT;
                end
            end
            PH_ZERO:
            begin
                do_after    = 1'b1;
                allow_point = 1'b1;
                bad_status  = ST_BAD_ZERO;
            end
            PH_INT:
            begin
                if (is_digit(txt))
                begin
                    do_int = 1'b1;
                end
                else
                begin
                    do_after    = 1'b1;
                    allow_point = 1'b1;
                end
            end
            PH_FRAC:
            begin
                if (is_digit(txt))
                begin
                    if (!(&frac_cnt_reg))
                    begin
                        frac_tok = frac_cnt_reg + 1'b1;
                    end
                    len_tok = len_inc;
                end
                else if (frac_cnt_reg == '0)
                begin
                    hit        = 1'b1;
                    hit_status = ST_NO_FRAC;
                end
                else
                begin
                    do_after = 1'b1;
                end
            end
            PH_EXPMARK:
            begin
                if ((txt == CH_MINUS) || (txt == CH_PLUS))
                begin
                    exp_minus_tok = (txt == CH_MINUS);
                    len_tok       = len_inc;
                    phase_tok     = PH_EXP;
                end
                else if (is_digit(txt))
                begin
                    do_exp = 1'b1;
                end
                else
                begin
                    hit        = 1'b1;
                    hit_status = ST_NO_EXP;
                end
            end
            PH_EXP:
            begin
                if (is_digit(txt))
                begin
                    do_exp = 1'b1;
                end
                else if (!exp_seen_reg)
                begin
                    hit        = 1'b1;
                    hit_status = ST_NO_EXP;
                end
                else
                begin
                    hit        = 1'b1;
                    hit_status = is_term(txt) ? ST_OK : ST_BAD_TAIL;
                end
            end
            default:
            begin
                phase_tok = phase_reg;
            end
        endcase

        // integer digit, a leading zero stands alone and is not checked
        if (do_int)
        begin
            if (zero_lead)
            begin
                int_tok   = CNT_W'(1);
                len_tok   = len_inc;
                phase_tok = PH_ZERO;
            end
            else if (int_cnt_reg >= cfg.max_int_digits)
            begin
                hit        = 1'b1;
                hit_status = ST_INT_OVF;
            end
            else
            begin
                int_tok   = int_cnt_reg + 1'b1;
                len_tok   = len_inc;
                phase_tok = PH_INT;
            end
        end

        // exponent digit with running limit check
        if (do_exp)
        begin
            if (exp_sum > EXP_SUM_W'(cfg.max_exp_value))
            begin
                hit        = 1'b1;
                hit_status = ST_EXP_OVF;
            end
            else
            begin
                exp_tok      = exp_sum[EXP_W-1:0];
                exp_seen_tok = 1'b1;
                len_tok      = len_inc;
                phase_tok    = PH_EXP;
            end
        end

        // after a digit run: point, exponent mark or terminator
        if (do_after)
        begin
            if (allow_point && (txt == CH_POINT))
            begin
                len_tok   = len_inc;
                phase_tok = PH_FRAC;
            end
            else if ((txt == CH_E_LO) || (txt == CH_E_UP))
            begin
                len_tok   = len_inc;
                phase_tok = PH_EXPMARK;
            end
            else
            begin
                hit        = 1'b1;
                hit_status = is_term(txt) ? ST_OK : bad_status;
            end
        end
    end

    // status when the buffer ends without an earlier close
    always_comb
    begin
        unique case (phase_tok)
            PH_WS, PH_SIGN: end_status = ST_NO_DIGIT;
            PH_FRAC:        end_status = (frac_tok == '0) ? ST_NO_FRAC : ST_OK;
            PH_EXPMARK:     end_status = ST_NO_EXP;
            PH_EXP:         end_status = exp_seen_tok ? ST_OK : ST_NO_EXP;
            default:        end_status = ST_OK;
        endcase
    end

    // length seen at the result port, saturating to its width
    if (LENGTH_BITS > TOKEN_LEN_W)
    begin : g_len_sat
        assign len_out = (|len_tok[LENGTH_BITS-1:TOKEN_LEN_W]) ? '1
                                                               : len_tok[TOKEN_LEN_W-1:0];
    end
    else
    begin : g_len_ext
        assign len_out = TOKEN_LEN_W'(len_tok);
    end

    // result assembly
    assign got = step && active && (hit || last);

    always_comb
    begin
        res.status            = hit ? hit_status : end_status;
        res.token_length      = len_out;
        res.is_negative       = minus_tok;
        res.integer_form      = phase_tok inside {PH_WS, PH_SIGN, PH_ZERO, PH_INT};
        res.integer_digits    = int_tok;
        res.fraction_digits   = frac_tok;
        res.exponent_value    = exp_tok;
        res.exponent_negative = exp_minus_tok;
    end

    // state update, the buffer's last byte always starts a fresh token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WS;
            len_reg       <= '0;
            int_cnt_reg   <= '0;
            frac_cnt_reg  <= '0;
            exp_acc_reg   <= '0;
            exp_seen_reg  <= 1'b0;
            exp_minus_reg <= 1'b0;
            minus_reg     <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                phase_reg     <= PH_WS;
                len_reg       <= '0;
                int_cnt_reg   <= '0;
                frac_cnt_reg  <= '0;
                exp_acc_reg   <= '0;
                exp_seen_reg  <= 1'b0;
                exp_minus_reg <= 1'b0;
                minus_reg     <= 1'b0;
            end
            else if (active)
            begin
                phase_reg     <= hit ? PH_DONE : phase_tok;
                len_reg       <= len_tok;
                int_cnt_reg   <= int_tok;
                frac_cnt_reg  <= frac_tok;
                exp_acc_reg   <= exp_tok;
                exp_seen_reg  <= exp_seen_tok;
                exp_minus_reg <= exp_minus_tok;
                minus_reg     <= minus_tok;
            end
        end
    end

endmodule
